/* rtl/signed_int_to_decimal_ascii_assert.svh */
// Assertion macros used by the signed integer to decimal text back end.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
`define SI2DEC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SI2DEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SI2DEC_ASSERT(lbl, clk, rst, prop, msg)
`define SI2DEC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/si2dec_pkg.sv */
// Package: widths, codes, queue entry type, back-end states and the double-dabble step.
package si2dec_pkg;

   localparam int VALUE_W       = 32;
   localparam int CHAR_W        = 8;
   localparam int DIGITS        = 10;
   localparam int DIGIT_W       = 4;
   localparam int BCD_W         = DIGITS * DIGIT_W;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
   localparam int IDX_W         = $clog2(DIGITS);
   localparam int FIFO_DEPTH    = 2;
   localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

   localparam logic [CHAR_W-1:0]     ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]     ASCII_MINUS = 8'h2D;
   localparam logic [DIGIT_W-1:0]    MAX_DIGIT   = DIGIT_W'(9);
   localparam logic [STEP_CNT_W-1:0] LAST_STEP   = STEP_CNT_W'(CONV_STEPS - 1);

   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_LEAD,
      ST_EMIT
   } back_state_type;

   // one shift-add-3 step: correct every digit >= 5, then shift in the next bit
   function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                   input logic             bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

endpackage

/* rtl/si2dec_channels.sv */
// Channel interfaces: request (signed value) and response (one character).
interface si2dec_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [si2dec_pkg::VALUE_W-1:0]    value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface si2dec_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [si2dec_pkg::CHAR_W-1:0]     character;
   logic                              last_char;
   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

/* rtl/si2dec_front.sv */
// Front end: takes a request, splits sign and 32-bit magnitude, feeds the queue.
module si2dec_front (
   input  logic                 clock,
   input  logic                 reset,
   si2dec_req_if.sink           req_chan,
   output logic                 push_valid,
   input  logic                 push_ready,
   output si2dec_pkg::item_type push_item
);

   logic                                valid_ff, valid_in;
   si2dec_pkg::item_type                item_ff, item_in;
   si2dec_pkg::item_type                classed;
   logic                                accept;
   logic [si2dec_pkg::VALUE_W-1:0]      raw;

   assign req_chan.ready = !valid_ff || push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign raw            = req_chan.value;

   // two's complement magnitude; the most negative value maps to 2^31
   always_comb begin
      classed.neg = raw[si2dec_pkg::VALUE_W-1];
      classed.mag = classed.neg ? (~raw + si2dec_pkg::VALUE_W'(1)) : raw;
   end

   always_comb begin
      valid_in = accept || (valid_ff && !push_ready);
      item_in  = accept ? classed : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

/* rtl/si2dec_fifo.sv */
// Short queue of classified items between the front and back ends.
module si2dec_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  si2dec_pkg::item_type push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output si2dec_pkg::item_type pop_item
);

   si2dec_pkg::item_type                  entries_ff [si2dec_pkg::FIFO_DEPTH];
   logic [si2dec_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [si2dec_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [si2dec_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                                  do_push, do_pop;

   function automatic logic [si2dec_pkg::FIFO_PTR_W-1:0] next_ptr(
      input logic [si2dec_pkg::FIFO_PTR_W-1:0] ptr);
      if (ptr == si2dec_pkg::FIFO_PTR_W'(si2dec_pkg::FIFO_DEPTH - 1)) begin
         return '0;
      end
      return ptr + si2dec_pkg::FIFO_PTR_W'(1);
   endfunction

   assign push_ready = count_ff != si2dec_pkg::FIFO_CNT_W'(si2dec_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + si2dec_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - si2dec_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/si2dec_back.sv */
// Back end: iterative binary to BCD conversion, then one character per transfer.
`include "signed_int_to_decimal_ascii_assert.svh"
module si2dec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  si2dec_pkg::item_type pop_item,
   si2dec_rsp_if.source         rsp_chan
);

   si2dec_pkg::back_state_type            state_ff, state_in;
   logic [si2dec_pkg::VALUE_W-1:0]        shreg_ff, shreg_in;
   logic [si2dec_pkg::BCD_W-1:0]          bcd_ff, bcd_in;
   logic [si2dec_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [si2dec_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic                                  sign_ff, sign_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [si2dec_pkg::CHAR_W-1:0]         rsp_char_ff, rsp_char_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic                                  out_free;
   logic                                  load;
   logic [si2dec_pkg::DIGIT_W-1:0]        cur_digit;
   logic [si2dec_pkg::IDX_W-1:0]          lead;
   logic [si2dec_pkg::BCD_W-1:0]          bcd_step;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign cur_digit = bcd_ff[idx_ff*si2dec_pkg::DIGIT_W +: si2dec_pkg::DIGIT_W];

   // highest nonzero digit; all zero leaves index 0 so zero prints as "0"
   always_comb begin
      lead = '0;
      for (int d = 0; d < si2dec_pkg::DIGITS; d++) begin
         if (bcd_ff[d*si2dec_pkg::DIGIT_W +: si2dec_pkg::DIGIT_W] != '0) begin
            lead = si2dec_pkg::IDX_W'(d);
         end
      end
   end

   // four dabble steps per cycle, MSB of the magnitude first
   always_comb begin
      bcd_step = bcd_ff;
      for (int j = 0; j < si2dec_pkg::BITS_PER_STEP; j++) begin
         bcd_step = si2dec_pkg::dabble_bit(bcd_step, shreg_ff[si2dec_pkg::VALUE_W-1-j]);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         si2dec_pkg::ST_IDLE: begin
            if (pop_valid) begin
               state_in = si2dec_pkg::ST_CONV;
            end
         end
         si2dec_pkg::ST_CONV: begin
            if (cnt_ff == si2dec_pkg::LAST_STEP) begin
               state_in = si2dec_pkg::ST_LEAD;
            end
         end
         si2dec_pkg::ST_LEAD: begin
            state_in = si2dec_pkg::ST_EMIT;
         end
         si2dec_pkg::ST_EMIT: begin
            if (out_free && !sign_ff && idx_ff == '0) begin
               state_in = si2dec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = si2dec_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      pop_ready   = 1'b0;
      load        = 1'b0;
      shreg_in    = shreg_ff;
      bcd_in      = bcd_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      sign_in     = sign_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         si2dec_pkg::ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               shreg_in = pop_item.mag;
               bcd_in   = '0;
               cnt_in   = '0;
               sign_in  = pop_item.neg;
            end
         end
         si2dec_pkg::ST_CONV: begin
            shreg_in = shreg_ff << si2dec_pkg::BITS_PER_STEP;
            bcd_in   = bcd_step;
            cnt_in   = cnt_ff + si2dec_pkg::STEP_CNT_W'(1);
         end
         si2dec_pkg::ST_LEAD: begin
            idx_in = lead;
         end
         si2dec_pkg::ST_EMIT: begin
            if (out_free) begin
               load = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = si2dec_pkg::ASCII_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in = si2dec_pkg::ASCII_ZERO + si2dec_pkg::CHAR_W'(cur_digit);
                  rsp_last_in = idx_ff == '0;
                  if (idx_ff != '0) begin
                     idx_in = idx_ff - si2dec_pkg::IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= si2dec_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shreg_ff    <= shreg_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      sign_ff     <= sign_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;
   assign rsp_chan.last_char = rsp_last_ff;

   `SI2DEC_ASSERT(a_conv_ends, clock, reset, (state_ff == si2dec_pkg::ST_CONV && cnt_ff == si2dec_pkg::LAST_STEP) |=> (state_ff == si2dec_pkg::ST_LEAD), "conversion did not end after the last step")
   `SI2DEC_ASSERT(a_digit_bcd, clock, reset, (state_ff == si2dec_pkg::ST_EMIT) |-> (cur_digit <= si2dec_pkg::MAX_DIGIT), "emitted digit is not decimal")
   `SI2DEC_ASSERT(a_last_to_idle, clock, reset, (load && rsp_last_in) |=> (state_ff == si2dec_pkg::ST_IDLE), "back end busy after the final character")
   `SI2DEC_ASSERT_ALWAYS(a_minus_not_last, clock, (rsp_valid_ff && rsp_char_ff == si2dec_pkg::ASCII_MINUS) |-> !rsp_last_ff, "minus sign flagged as final character")

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Top level: signed 32-bit integer to decimal ASCII text, one character per transfer.
//
// req_chan carries one signed 32-bit value per transfer (valid/ready).
// rsp_chan returns its decimal text, most significant character first:
// a '-' for negative values, then the digits without leading zeros, with
// last_char set on the final digit. Zero gives "0"; -2147483648 gives
// eleven characters. Runs for different values never interleave.
// The path from request transfer to the first character runs through the
// front register, the queue, the binary-to-BCD pass at four bits a
// cycle and the ST_LEAD step that finds the leading digit.
// The back end takes one value at a time and, for each, runs the BCD pass,
// then sends its N characters (1 to 11) through the one-character output
// register. The front end and a two-entry queue keep taking requests
// while the back end is busy.
// Reset is synchronous; it empties the queue and drops any pending output.
// When the receiver holds rsp_chan.ready low the current character stays
// put, the back end stops, and requests back up once the queue is full.
module signed_int_to_decimal_ascii (
   input  logic          clock,
   input  logic          reset,
   si2dec_req_if.sink    req_chan,
   si2dec_rsp_if.source  rsp_chan
);

   logic                 push_valid, push_ready;
   logic                 pop_valid, pop_ready;
   si2dec_pkg::item_type push_item, pop_item;

   si2dec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   si2dec_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   si2dec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule
